// ===== hdl/utf8_codepoint_histogram_defines.svh =====
// ----------------------------------------------------------------------------
// utf8_codepoint_histogram_defines.svh
// Assertion macros shared by the histogram RTL files.
// ----------------------------------------------------------------------------
`ifndef UTF8_CODEPOINT_HISTOGRAM_DEFINES_SVH
`define UTF8_CODEPOINT_HISTOGRAM_DEFINES_SVH

`ifndef ASSERT_OFF

// clocked check, masked while reset is asserted
`define U8H_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("u8h assertion failed");

// clocked check that also holds during reset
`define U8H_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("u8h assertion failed");

`else

`define U8H_ASSERT(lbl, clk, rst_n, prop)
`define U8H_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ===== hdl/u8h_pkg.sv =====
// ----------------------------------------------------------------------------
// u8h_pkg
// Types, constants and helpers of the utf-8 code point histogram.
// ----------------------------------------------------------------------------
`default_nettype none

package u8h_pkg;

    // counter and port widths
    localparam int COUNT_WIDTH = 32;
    localparam int READ_W      = 32;
    localparam int CP_W        = 21;
    localparam int PARTIAL_W   = 18;
    localparam int DROP_W      = 3;
    localparam int NEED_W      = 2;

    // bin layout: code points below 65536, then the above bin, then planes 1-16
    localparam int BMP_DEPTH   = 65536;
    localparam int PLANE_DEPTH = 17;
    localparam int BIN_DEPTH   = BMP_DEPTH + PLANE_DEPTH;
    localparam int BIN_AW      = $clog2(BIN_DEPTH);
    localparam int PLANE_LIMIT = PLANE_DEPTH * BMP_DEPTH;

    // result queue
    localparam int Q_DEPTH = 3;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // byte classes
    localparam logic [7:0] CONT_MASK = 8'hc0;
    localparam logic [7:0] CONT_TAG  = 8'h80;
    localparam logic [7:0] LEAD3_LO  = 8'he0;
    localparam logic [7:0] LEAD4_LO  = 8'hf0;
    localparam logic [7:0] BAD_LO    = 8'hf8;
    localparam logic [7:0] PAY2_MASK = 8'h1f;
    localparam logic [7:0] PAY3_MASK = 8'h0f;
    localparam logic [7:0] PAY4_MASK = 8'h07;
    localparam logic [7:0] CONT_PAY  = 8'h3f;

    typedef enum logic [1:0] {
        FN_DATA = 2'd0,
        FN_READ = 2'd1,
        FN_EOS  = 2'd2,
        FN_NOP  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_INCR = 2'd1,
        OP_READ = 2'd2
    } t_kind;

    // decoded item heading for the counter stage
    typedef struct packed {
        t_kind              kind;
        logic [BIN_AW-1:0]  addr;
        logic               char_done;
        logic [CP_W-1:0]    code_point;
        logic [DROP_W-1:0]  dropped;
        logic               pending;
    } t_op;

    // one finished result
    typedef struct packed {
        logic [READ_W-1:0]  read_count;
        logic               char_done;
        logic [CP_W-1:0]    code_point;
        logic [DROP_W-1:0]  dropped;
        logic               pending;
    } t_res;

    // counter stage status toward the top level
    typedef struct packed {
        logic clearing;
        logic s1_valid;
    } t_stat;

    // bin that counts a code point
    function automatic logic [BIN_AW-1:0] cp_bin(input logic [CP_W-1:0] cp);
        logic [BIN_AW-1:0] bin;
        if (int'(cp) < BMP_DEPTH) begin
            bin = BIN_AW'(cp);
        end else if (int'(cp) < PLANE_LIMIT) begin
            bin = BIN_AW'(BMP_DEPTH) + BIN_AW'(cp[CP_W-1:16]);
        end else begin
            bin = BIN_AW'(BMP_DEPTH);
        end
        return bin;
    endfunction

    // saturating increment
    function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] c);
        logic [COUNT_WIDTH-1:0] r;
        if (c == {COUNT_WIDTH{1'b1}}) begin
            r = c;
        end else begin
            r = c + COUNT_WIDTH'(1);
        end
        return r;
    endfunction

    // limit a counter to the read port width
    function automatic logic [READ_W-1:0] sat_read(input logic [COUNT_WIDTH-1:0] c);
        logic [COUNT_WIDTH+READ_W-1:0] ext;
        logic [COUNT_WIDTH+READ_W-1:0] upper;
        logic [READ_W-1:0]             r;
        ext   = {{READ_W{1'b0}}, c};
        upper = ext >> READ_W;
        if (upper != '0) begin
            r = {READ_W{1'b1}};
        end else begin
            r = ext[READ_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/u8h_ram.sv =====
// ----------------------------------------------------------------------------
// u8h_ram
// Generic single-write, single-read ram with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module u8h_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/u8h_decode.sv =====
// ----------------------------------------------------------------------------
// u8h_decode
// Utf-8 sequence tracker: turns each beat into a bin operation and result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "utf8_codepoint_histogram_defines.svh"

module u8h_decode (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_accept,
    input  wire logic                        i_utf8_mode,
    input  wire u8h_pkg::t_func              i_func,
    input  wire logic [7:0]                  i_data_byte,
    input  wire logic [u8h_pkg::BIN_AW-1:0]  i_bin_index,
    output u8h_pkg::t_op                     o_op
);
    import u8h_pkg::*;

    logic [PARTIAL_W-1:0] r_partial, n_partial;
    logic [NEED_W-1:0]    r_needed,  n_needed;
    logic [NEED_W-1:0]    r_held,    n_held;

    logic [CP_W-1:0] full;
    logic            is_cont;

    assign is_cont = (i_data_byte & CONT_MASK) == CONT_TAG;
    assign full    = {r_partial[CP_W-7:0], i_data_byte[5:0]};

    // next sequence state and the operation for this beat
    always_comb begin
        n_partial        = r_partial;
        n_needed         = r_needed;
        n_held           = r_held;
        o_op.kind        = OP_NONE;
        o_op.addr        = '0;
        o_op.char_done   = 1'b0;
        o_op.code_point  = '0;
        o_op.dropped     = '0;
        case (i_func)
            FN_READ: begin
                if (int'(i_bin_index) < BIN_DEPTH) begin
                    o_op.kind = OP_READ;
                    o_op.addr = i_bin_index;
                end
            end
            FN_EOS: begin
                o_op.dropped = DROP_W'(r_held);
                n_partial    = '0;
                n_needed     = '0;
                n_held       = '0;
            end
            FN_DATA: begin
                if (!i_utf8_mode) begin
                    // raw byte count, any held sequence is lost
                    o_op.dropped    = DROP_W'(r_held);
                    n_partial       = '0;
                    n_needed        = '0;
                    n_held          = '0;
                    o_op.kind       = OP_INCR;
                    o_op.addr       = BIN_AW'(i_data_byte);
                    o_op.char_done  = 1'b1;
                    o_op.code_point = CP_W'(i_data_byte);
                end else if (is_cont) begin
                    if (r_needed != '0) begin
                        if (r_needed == NEED_W'(1)) begin
                            // last continuation closes the character
                            o_op.kind       = OP_INCR;
                            o_op.addr       = cp_bin(full);
                            o_op.char_done  = 1'b1;
                            o_op.code_point = full;
                            n_partial       = '0;
                            n_needed        = '0;
                            n_held          = '0;
                        end else begin
                            n_partial = full[PARTIAL_W-1:0];
                            n_needed  = r_needed - NEED_W'(1);
                            n_held    = r_held + NEED_W'(1);
                        end
                    end else begin
                        // stray continuation
                        o_op.dropped = DROP_W'(1);
                    end
                end else begin
                    // new lead byte, drop anything held first
                    o_op.dropped = DROP_W'(r_held);
                    n_partial    = '0;
                    n_needed     = '0;
                    n_held       = '0;
                    if (i_data_byte < CONT_TAG) begin
                        o_op.kind       = OP_INCR;
                        o_op.addr       = BIN_AW'(i_data_byte);
                        o_op.char_done  = 1'b1;
                        o_op.code_point = CP_W'(i_data_byte);
                    end else if (i_data_byte < LEAD3_LO) begin
                        n_partial = PARTIAL_W'(i_data_byte & PAY2_MASK);
                        n_needed  = NEED_W'(1);
                        n_held    = NEED_W'(1);
                    end else if (i_data_byte < LEAD4_LO) begin
                        n_partial = PARTIAL_W'(i_data_byte & PAY3_MASK);
                        n_needed  = NEED_W'(2);
                        n_held    = NEED_W'(1);
                    end else if (i_data_byte < BAD_LO) begin
                        n_partial = PARTIAL_W'(i_data_byte & PAY4_MASK);
                        n_needed  = NEED_W'(3);
                        n_held    = NEED_W'(1);
                    end else begin
                        o_op.dropped = DROP_W'(r_held) + DROP_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
        o_op.pending = n_needed != '0;
    end

    // sequence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= '0;
            r_needed  <= '0;
            r_held    <= '0;
        end else if (i_accept) begin
            r_partial <= n_partial;
            r_needed  <= n_needed;
            r_held    <= n_held;
        end
    end

    // a sequence is held exactly when more bytes are expected
    `U8H_ASSERT(a_held_matches_needed, i_clk, i_rst_n, (r_needed != '0) == (r_held != '0))

endmodule

`default_nettype wire

// ===== hdl/u8h_count.sv =====
// ----------------------------------------------------------------------------
// u8h_count
// Bin memory with read-modify-write, same-bin forwarding and reset sweep.
// ----------------------------------------------------------------------------
`default_nettype none
`include "utf8_codepoint_histogram_defines.svh"

module u8h_count (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_op_valid,
    input  wire u8h_pkg::t_op  i_op,
    output logic               o_res_valid,
    output u8h_pkg::t_res      o_res,
    output u8h_pkg::t_stat     o_stat
);
    import u8h_pkg::*;

    logic r_s1_v;
    t_op  r_s1_op;

    logic              r_clr;
    logic [BIN_AW-1:0] r_clr_addr;

    logic                   r_fw_v;
    logic [BIN_AW-1:0]      r_fw_addr;
    logic [COUNT_WIDTH-1:0] r_fw_data;

    logic [COUNT_WIDTH-1:0] rdata;
    logic [COUNT_WIDTH-1:0] cur;
    logic [COUNT_WIDTH-1:0] bumped;
    logic                   incr;

    logic                   we;
    logic [BIN_AW-1:0]      waddr;
    logic [COUNT_WIDTH-1:0] wdata;

    // current count, taking the write of the previous cycle into account
    assign cur    = (r_fw_v && (r_fw_addr == r_s1_op.addr)) ? r_fw_data : rdata;
    assign bumped = bump(cur);
    assign incr   = r_s1_v && (r_s1_op.kind == OP_INCR);

    // write port: sweep first, then the counter update
    always_comb begin
        if (r_clr) begin
            we    = 1'b1;
            waddr = r_clr_addr;
            wdata = '0;
        end else begin
            we    = incr;
            waddr = r_s1_op.addr;
            wdata = bumped;
        end
    end

    u8h_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (BIN_DEPTH)
    ) u_bins (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (i_op_valid),
        .i_raddr (i_op.addr),
        .o_rdata (rdata)
    );

    // stage register, sweep counter and forwarding register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v     <= 1'b0;
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
            r_fw_v     <= 1'b0;
        end else begin
            r_s1_v <= i_op_valid;
            r_fw_v <= incr && !r_clr;
            if (r_clr) begin
                if (r_clr_addr == BIN_AW'(BIN_DEPTH - 1)) begin
                    r_clr <= 1'b0;
                end
                r_clr_addr <= r_clr_addr + BIN_AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op_valid) begin
            r_s1_op <= i_op;
        end
        r_fw_addr <= r_s1_op.addr;
        r_fw_data <= bumped;
    end

    // result of the stage
    assign o_res_valid        = r_s1_v;
    assign o_res.read_count   = (r_s1_op.kind == OP_READ) ? sat_read(cur) : '0;
    assign o_res.char_done    = r_s1_op.char_done;
    assign o_res.code_point   = r_s1_op.code_point;
    assign o_res.dropped      = r_s1_op.dropped;
    assign o_res.pending      = r_s1_op.pending;
    assign o_stat.clearing    = r_clr;
    assign o_stat.s1_valid    = r_s1_v;

    // no beat enters while the sweep runs
    `U8H_ASSERT(a_no_op_in_sweep, i_clk, i_rst_n, r_clr |-> !i_op_valid && !r_s1_v)
    // sweep stays inside the bin range
    `U8H_ASSERT(a_sweep_in_range, i_clk, i_rst_n, r_clr |-> int'(r_clr_addr) < BIN_DEPTH)

endmodule

`default_nettype wire

// ===== hdl/u8h_outq.sv =====
// ----------------------------------------------------------------------------
// u8h_outq
// Small result queue between the counter stage and the output channel.
// ----------------------------------------------------------------------------
`default_nettype none
`include "utf8_codepoint_histogram_defines.svh"

module u8h_outq (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_push,
    input  wire u8h_pkg::t_res                i_data,
    input  wire logic                         i_pop,
    output logic                              o_valid,
    output u8h_pkg::t_res                     o_data,
    output logic [u8h_pkg::Q_CNT_W-1:0]       o_count
);
    import u8h_pkg::*;

    t_res               r_slot [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_head, r_tail;
    logic [Q_CNT_W-1:0] r_count;
    logic               pop;

    assign pop     = i_pop && (r_count != '0);
    assign o_valid = r_count != '0;
    assign o_data  = r_slot[r_head];
    assign o_count = r_count;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_tail <= (r_tail == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_tail + Q_PTR_W'(1);
            end
            if (pop) begin
                r_head <= (r_head == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_head + Q_PTR_W'(1);
            end
            if (i_push && !pop) begin
                r_count <= r_count + Q_CNT_W'(1);
            end else if (pop && !i_push) begin
                r_count <= r_count - Q_CNT_W'(1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_tail] <= i_data;
        end
    end

    // the credit check upstream keeps the queue from overflowing
    `U8H_ASSERT(a_no_overflow, i_clk, i_rst_n, (i_push && !pop) |-> int'(r_count) < Q_DEPTH)

endmodule

`default_nettype wire

// ===== hdl/utf8_codepoint_histogram.sv =====
// ----------------------------------------------------------------------------
// utf8_codepoint_histogram
// Byte stream histogram with utf-8 decoding and saturating bin counters.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_ready): one beat per item. i_func selects a
// stream byte, a bin read or an end-of-stream mark. Every beat gives exactly
// one result beat on the output channel (o_valid / i_ready), in order.
// With an empty queue o_valid rises once the result is loaded: the bin
// memory read is registered at acceptance, the next cycle updates the
// count, writes it back, forwards it to a following beat on the same bin
// and loads the queue. Throughput is one beat per cycle while no sweep runs
// and the receiver takes results, set by the single read-modify-write port
// pair of the bin memory.
// i_cfg_we writes utf8_mode from i_cfg_data; 0 counts raw byte values, 1
// decodes utf-8. Write it only while no beats are in flight.
// After reset o_ready stays low while the bin memory is swept to zero, one
// bin per cycle; configuration writes are taken then.
// A three-entry result queue absorbs a stalled receiver; o_ready drops once
// in-flight beats fill it and rises again as results are taken.
// ----------------------------------------------------------------------------
`default_nettype none
`include "utf8_codepoint_histogram_defines.svh"

module utf8_codepoint_histogram (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_data,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [1:0]                    i_func,
    input  wire logic [7:0]                    i_data_byte,
    input  wire logic [u8h_pkg::BIN_AW-1:0]    i_bin_index,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [u8h_pkg::READ_W-1:0]         o_read_count,
    output logic                               o_char_done,
    output logic [u8h_pkg::CP_W-1:0]           o_code_point,
    output logic [u8h_pkg::DROP_W-1:0]         o_dropped_bytes,
    output logic                               o_sequence_pending
);
    import u8h_pkg::*;

    logic               r_utf8_mode;
    logic               accept;
    t_op                op;
    logic               res_valid;
    t_res               res;
    t_stat              stat;
    t_res               q_data;
    logic [Q_CNT_W-1:0] q_count;
    logic [Q_CNT_W:0]   in_flight;

    // mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_utf8_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_utf8_mode <= i_cfg_data;
        end
    end

    // credit: beats in the counter stage plus beats queued
    assign in_flight = {1'b0, q_count} + (Q_CNT_W + 1)'(stat.s1_valid);
    assign o_ready   = !stat.clearing && (int'(in_flight) < Q_DEPTH);
    assign accept    = i_valid && o_ready;

    u8h_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_utf8_mode (r_utf8_mode),
        .i_func      (t_func'(i_func)),
        .i_data_byte (i_data_byte),
        .i_bin_index (i_bin_index),
        .o_op        (op)
    );

    u8h_count u_count (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op_valid  (accept),
        .i_op        (op),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_stat      (stat)
    );

    u8h_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .i_pop   (i_ready),
        .o_valid (o_valid),
        .o_data  (q_data),
        .o_count (q_count)
    );

    // output fields
    assign o_read_count       = q_data.read_count;
    assign o_char_done        = q_data.char_done;
    assign o_code_point       = q_data.code_point;
    assign o_dropped_bytes    = q_data.dropped;
    assign o_sequence_pending = q_data.pending;

    // every accepted beat reaches the queue in the next cycle
    `U8H_ASSERT(a_beat_reaches_stage, i_clk, i_rst_n, accept |=> res_valid)

endmodule

`default_nettype wire

// ===== test/utf8_codepoint_histogram_tb.sv =====
// ----------------------------------------------------------------------------
// utf8_codepoint_histogram_tb
// Self-checking bench for the byte stream / utf-8 code point histogram. A
// scoreboard class keeps its own bin counters and decoder state, predicts
// one result per accepted beat and checks every result beat in order.
// Stimulus is a short directed list followed by random phases in both modes
// with random idling on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
module utf8_codepoint_histogram_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import u8h_pkg::*;

    localparam bit MODE_BYTES     = 1'b0;
    localparam bit MODE_UTF8      = 1'b1;
    localparam int RESET_CYCLES   = 5;
    localparam int CYCLE_LIMIT    = 500_000;
    localparam int DRAIN_CYCLES   = 6;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_BEATS    = 300;
    localparam int NUM_PHASES     = 6;
    localparam int QUIET_PHASE    = 2;
    localparam int PRESSURE_PHASE = 3;
    localparam int MAX_REPORTS    = 100;
    // mode per random phase, bit 0 first
    localparam bit [NUM_PHASES-1:0] PHASE_MODES = 6'b101101;

    // predicted bin counters, decoder state and expected result beats
    class histogram_model;
        bit                     mode;
        logic [COUNT_WIDTH-1:0] bin_counts [BIN_DEPTH];
        logic [PARTIAL_W-1:0]   partial;
        logic [1:0]             need;
        logic [1:0]             held;
        logic [BIN_AW-1:0]      last_bin;
        t_res                   expected_results [$];
        int                     mismatches;
        int                     n_beats;
        int                     n_counted;
        int                     n_reads;
        int                     n_dropped;

        function new();
            foreach (bin_counts[i]) bin_counts[i] = '0;
            mode       = MODE_BYTES;
            partial    = '0;
            need       = '0;
            held       = '0;
            last_bin   = '0;
            mismatches = 0;
            n_beats    = 0;
            n_counted  = 0;
            n_reads    = 0;
            n_dropped  = 0;
        endfunction

        function void clear_sequence();
            partial = '0;
            need    = '0;
            held    = '0;
        endfunction

        // saturating increment of the bin that holds a code point
        function void count_point(logic [CP_W-1:0] cp);
            logic [BIN_AW-1:0] bin;
            if (int'(cp) < BMP_DEPTH) begin
                bin = BIN_AW'(cp[15:0]);
            end else if (int'(cp) < PLANE_LIMIT) begin
                bin = BIN_AW'(BMP_DEPTH + int'(cp[CP_W-1:16]));
            end else begin
                bin = BIN_AW'(BMP_DEPTH);
            end
            if (bin_counts[bin] != '1) bin_counts[bin] = bin_counts[bin] + 1'b1;
            last_bin = bin;
        endfunction

        // predict the result of one accepted beat
        function void take_item(t_func f, logic [7:0] b, logic [BIN_AW-1:0] idx);
            t_res            r;
            logic [CP_W-1:0] full;
            r = '0;
            n_beats++;
            case (f)
                FN_READ: begin
                    n_reads++;
                    if (int'(idx) < BIN_DEPTH) begin
                        r.read_count = (bin_counts[idx] > {READ_W{1'b1}})
                                       ? {READ_W{1'b1}} : bin_counts[idx][READ_W-1:0];
                    end
                end
                FN_EOS: begin
                    r.dropped = DROP_W'(held);
                    clear_sequence();
                end
                FN_DATA: begin
                    if (mode == MODE_BYTES) begin
                        // held bytes from utf-8 mode are flushed first
                        r.dropped = DROP_W'(held);
                        clear_sequence();
                        count_point(CP_W'(b));
                        r.char_done  = 1'b1;
                        r.code_point = CP_W'(b);
                    end else if (b[7:6] == 2'b10) begin
                        // continuation byte
                        if (need != 0) begin
                            full = CP_W'({partial, b[5:0]});
                            need = need - 1'b1;
                            held = held + 1'b1;
                            if (need == 0) begin
                                count_point(full);
                                r.char_done  = 1'b1;
                                r.code_point = full;
                                clear_sequence();
                            end else begin
                                partial = full[PARTIAL_W-1:0];
                            end
                        end else begin
                            r.dropped = DROP_W'(1);
                        end
                    end else begin
                        // new lead: any partial sequence is dropped
                        r.dropped = DROP_W'(held);
                        clear_sequence();
                        if (b < 8'h80) begin
                            count_point(CP_W'(b));
                            r.char_done  = 1'b1;
                            r.code_point = CP_W'(b);
                        end else if (b < 8'he0) begin
                            partial = PARTIAL_W'(b & 8'h1f);
                            need    = 2'd1;
                            held    = 2'd1;
                        end else if (b < 8'hf0) begin
                            partial = PARTIAL_W'(b & 8'h0f);
                            need    = 2'd2;
                            held    = 2'd1;
                        end else if (b < 8'hf8) begin
                            partial = PARTIAL_W'(b & 8'h07);
                            need    = 2'd3;
                            held    = 2'd1;
                        end else begin
                            r.dropped = r.dropped + 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
            r.pending = (need != 0);
            if (r.char_done) n_counted++;
            n_dropped += int'(r.dropped);
            expected_results.push_back(r);
        endfunction

        function void note_mismatch(string field, logic [31:0] want, logic [31:0] got);
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
            end
        endfunction

        // compare one result beat with the oldest expectation
        function void check_result(t_res got);
            t_res want;
            if (expected_results.size() == 0) begin
                mismatches++;
                $display("%0t: result beat with nothing expected, got %h", $time, got);
                return;
            end
            want = expected_results.pop_front();
            if (got.read_count !== want.read_count)
                note_mismatch("read_count", want.read_count, got.read_count);
            if (got.char_done !== want.char_done)
                note_mismatch("char_done", 32'(want.char_done), 32'(got.char_done));
            if (got.code_point !== want.code_point)
                note_mismatch("code_point", 32'(want.code_point), 32'(got.code_point));
            if (got.dropped !== want.dropped)
                note_mismatch("dropped_bytes", 32'(want.dropped), 32'(got.dropped));
            if (got.pending !== want.pending)
                note_mismatch("sequence_pending", 32'(want.pending), 32'(got.pending));
        endfunction
    endclass

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_we    = 1'b0;
    logic              i_cfg_data  = 1'b0;
    logic              i_valid     = 1'b0;
    logic [1:0]        i_func      = 2'b00;
    logic [7:0]        i_data_byte = 8'h00;
    logic [BIN_AW-1:0] i_bin_index = '0;
    logic              i_ready     = 1'b0;
    logic              o_ready;
    logic              o_valid;
    logic [READ_W-1:0] o_read_count;
    logic              o_char_done;
    logic [CP_W-1:0]   o_code_point;
    logic [DROP_W-1:0] o_dropped_bytes;
    logic              o_sequence_pending;

    histogram_model model;
    bit             send_idle_on = 1'b1;
    bit             recv_idle_on = 1'b1;
    bit             hold_request = 1'b0;
    int             hold_left    = 0;
    int             cycles       = 0;

    utf8_codepoint_histogram dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_data         (i_cfg_data),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_func             (i_func),
        .i_data_byte        (i_data_byte),
        .i_bin_index        (i_bin_index),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_read_count       (o_read_count),
        .o_char_done        (o_char_done),
        .o_code_point       (o_code_point),
        .o_dropped_bytes    (o_dropped_bytes),
        .o_sequence_pending (o_sequence_pending)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side: check accepted beats, drive ready with idling and hold-off
    initial begin : result_sink
        t_res got;
        forever begin
            @(posedge i_clk);
            if (o_valid === 1'b1 && i_ready === 1'b1) begin
                got.read_count = o_read_count;
                got.char_done  = o_char_done;
                got.code_point = o_code_point;
                got.dropped    = o_dropped_bytes;
                got.pending    = o_sequence_pending;
                model.check_result(got);
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
                i_ready     <= 1'b0;
            end else begin
                i_ready <= !(recv_idle_on && $urandom_range(0, 99) < 9);
            end
        end
    end

    function automatic logic [BIN_AW-1:0] rand_index();
        return BIN_AW'($urandom_range(0, (1 << BIN_AW) - 1));
    endfunction

    // half the time the last counted bin, else bins around the plane bins and just past the bin range, or any index
    function automatic logic [BIN_AW-1:0] pick_read_bin();
        int pick;
        pick = $urandom_range(0, 3);
        if (pick < 2) return model.last_bin;
        if (pick == 2) return BIN_AW'($urandom_range(BMP_DEPTH - 4, BIN_DEPTH + 4));
        return rand_index();
    endfunction

    // offer one input beat and wait until it is taken
    task automatic push_beat(input t_func f, input logic [7:0] b,
                             input logic [BIN_AW-1:0] idx);
        while (send_idle_on && $urandom_range(0, 99) < 9) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_func      <= f;
        i_data_byte <= b;
        i_bin_index <= idx;
        @(posedge i_clk);
        while (o_ready !== 1'b1) @(posedge i_clk);
        model.take_item(f, b, idx);
    endtask

    task automatic push_data(input logic [7:0] b);
        push_beat(FN_DATA, b, rand_index());
    endtask

    // stop sending and wait for every expected result
    task automatic drain();
        i_valid <= 1'b0;
        while (model.expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mode(input bit m);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= m;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        model.mode = m;
    endtask

    // one utf-8 character with random payload, a few cut short
    task automatic send_utf8_char();
        int         len;
        int         conts;
        logic [7:0] lead;
        len = $urandom_range(1, 4);
        case (len)
            1:       lead = 8'($urandom_range(8'h00, 8'h7f));
            2:       lead = 8'($urandom_range(8'hc0, 8'hdf));
            3:       lead = 8'($urandom_range(8'he0, 8'hef));
            default: lead = 8'($urandom_range(8'hf0, 8'hf7));
        endcase
        conts = len - 1;
        if (len > 1 && $urandom_range(0, 9) == 0) conts = $urandom_range(0, len - 2);
        push_data(lead);
        repeat (conts) push_data(8'($urandom_range(8'h80, 8'hbf)));
    endtask

    task automatic send_random_item();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            push_beat(FN_READ, 8'($urandom), pick_read_bin());
        end else if (pick < 10) begin
            push_beat(FN_EOS, 8'($urandom), rand_index());
        end else if (pick == 10) begin
            push_beat(FN_NOP, 8'($urandom), rand_index());
        end else if (model.mode == MODE_BYTES || pick < 20) begin
            push_beat(FN_DATA, 8'($urandom), rand_index());
        end else begin
            send_utf8_char();
        end
    endtask

    // stimulus
    initial begin : stimulus
        int stop_at;
        model = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // taken while the bins are still being swept
        write_mode(MODE_UTF8);

        // ascii extremes, 3-byte, plane 1, top of the above bin
        push_data(8'h00);
        push_data(8'h7f);
        push_data(8'he2);
        push_data(8'h82);
        push_data(8'hac);
        push_data(8'hf0);
        push_data(8'h9f);
        push_data(8'h98);
        push_data(8'h80);
        push_data(8'hf7);
        push_data(8'hbf);
        push_data(8'hbf);
        push_data(8'hbf);
        // stray continuation, invalid lead, lead cut by ascii
        push_data(8'h80);
        push_data(8'hff);
        push_data(8'hc3);
        push_data(8'h41);
        // end of stream drops a partial sequence
        push_data(8'hf0);
        push_data(8'h90);
        push_beat(FN_EOS, 8'h00, '0);
        push_beat(FN_READ, 8'hff, BIN_AW'(BMP_DEPTH + 1));
        push_beat(FN_READ, 8'h00, BIN_AW'(BMP_DEPTH));
        push_beat(FN_READ, 8'h00, BIN_AW'(8'h41));
        push_beat(FN_READ, 8'h00, '1);
        push_beat(FN_NOP, 8'hff, '1);
        // mode switch with a sequence held
        push_data(8'he2);
        drain();
        write_mode(MODE_BYTES);
        push_data(8'hff);
        push_data(8'h00);
        push_beat(FN_READ, 8'h00, BIN_AW'(8'hff));

        // random phases
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            write_mode(PHASE_MODES[p]);
            send_idle_on = (p != QUIET_PHASE);
            recv_idle_on = (p != QUIET_PHASE);
            if (p == PRESSURE_PHASE) hold_request = 1'b1;
            stop_at = model.n_beats + PHASE_BEATS;
            while (model.n_beats < stop_at) send_random_item();
        end
        drain();

        $display("covered %0d beats in byte and utf-8 modes: %0d counted, %0d bin reads",
                 model.n_beats, model.n_counted, model.n_reads);
        $display("%0d bytes dropped; one long receiver hold-off, one phase without idling",
                 model.n_dropped);
        if (model.mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
